/* sv/order_book_side_levels_defines.svh */
// Assertion helpers for the file that checks its own logic.
`ifndef ORDER_BOOK_SIDE_LEVELS_DEFINES_SVH
`define ORDER_BOOK_SIDE_LEVELS_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define OBSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define OBSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/obsl_pkg.sv */
`timescale 1ns / 1ps
package obsl_pkg;

  localparam int LEVEL_SLOTS = 256;
  localparam int ORDER_SLOTS = 1024;
  localparam int LAW = $clog2(LEVEL_SLOTS);
  localparam int OAW = $clog2(ORDER_SLOTS);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TAKE   = 2'd2,
    ACT_REVISE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_NEW     = 2'd0,
    PH_TRADED  = 2'd1,
    PH_REVISED = 2'd2,
    PH_OFF     = 2'd3
  } phase_e;

  typedef struct packed {
    logic           resting;
    logic [LAW-1:0] lvl;
    logic [31:0]    residual;
    logic [31:0]    executed;
    logic [31:0]    total;
    logic [31:0]    minimum;
    logic [30:0]    price;
    phase_e         phase;
    logic [47:0]    mtime;
  } order_t;

  typedef struct packed {
    logic [32:0] key;
    logic [31:0] sum;
    logic [10:0] count;
  } level_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic lvl_read;
    logic check;
    logic exec_upd;
    logic scan_init;
    logic scan_step;
    logic scan_flush;
    logic ins_upd;
    logic fail;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic clr_last;
    logic early_err;
    logic is_insert;
    logic scan_last;
    logic late_err;
  } sts_t;

endpackage

/* sv/obsl_ram.sv */
`timescale 1ns / 1ps
module obsl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/obsl_ctrl.sv */
`timescale 1ns / 1ps
module obsl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  obsl_pkg::sts_t sts_i,
  output obsl_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import obsl_pkg::*;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_EXEC = 8'b0001_0000,
    S_SCAN = 8'b0010_0000,
    S_SEND = 8'b0100_0000,
    S_INS  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (sts_i.early_err) begin
          cmd_o.fail = 1'b1;
          state_d = S_IDLE;
        end else if (sts_i.is_insert) begin
          cmd_o.scan_init = 1'b1;
          state_d = S_SCAN;
        end else begin
          cmd_o.lvl_read = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.check = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.late_err) cmd_o.fail = 1'b1;
        else cmd_o.exec_upd = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_SEND;
      end
      S_SEND: begin
        cmd_o.scan_flush = 1'b1;
        state_d = S_INS;
      end
      S_INS: begin
        cmd_o.ins_upd = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/obsl_dp.sv */
`timescale 1ns / 1ps
module obsl_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  obsl_pkg::cmd_t cmd_i,
  output obsl_pkg::sts_t sts_o,
  input  logic [1:0]     action_i,
  input  logic [9:0]     order_slot_i,
  input  logic           is_buy_i,
  input  logic [30:0]    price_ticks_i,
  input  logic [31:0]    lot_quantity_i,
  input  logic [31:0]    executed_lots_i,
  input  logic [31:0]    minimum_lots_i,
  input  logic [47:0]    timestamp_i,
  output logic           valid_o,
  output logic [1:0]     status_o,
  output logic [30:0]    level_price_o,
  output logic [31:0]    level_total_lots_o,
  output logic [10:0]    level_order_count_o,
  output logic [31:0]    order_resting_lots_o,
  output logic [31:0]    order_executed_total_o,
  output logic [1:0]     order_status_o,
  output logic [30:0]    last_trade_price_o,
  output logic [31:0]    last_trade_lots_o,
  output logic [47:0]    last_trade_time_o
);
  import obsl_pkg::*;

  // Captured command.
  action_e        act_q;
  logic [OAW-1:0] slot_q;
  logic           slot_bad_q;
  logic [32:0]    key_q;
  logic [30:0]    price_q;
  logic [31:0]    qty_q, exe_q, min_q;
  logic [47:0]    now_q;
  logic [31:0]    resd_q;

  // Memories.
  logic           ord_we, lvl_we, lvl_re;
  logic [OAW-1:0] ord_waddr;
  logic [LAW-1:0] lvl_waddr, lvl_raddr;
  order_t         ord_rd, ord_wdata;
  level_t         lvl_rd, lvl_wdata;
  logic [LEVEL_SLOTS-1:0] in_use_q;

  logic [OAW-1:0] clr_idx_q;

  // Scan and check state.
  logic [LAW-1:0] scan_idx_q, chk_idx_q, found_idx_q, free_idx_q;
  logic           chk_v_q, found_v_q, free_v_q;
  level_t         found_w_q;
  logic [31:0]    delta_q;
  logic           lt_q, late_err_q;

  // Result registers.
  logic           valid_q;
  status_e        status_q;
  logic [30:0]    res_price_q;
  logic [31:0]    res_total_q, res_resid_q, res_exec_q;
  logic [10:0]    res_count_q;
  phase_e         res_phase_q;
  logic [30:0]    last_price_q;
  logic [31:0]    last_lots_q;
  logic [47:0]    last_time_q;

  obsl_ram #(.W($bits(order_t)), .D(ORDER_SLOTS)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (OAW'(order_slot_i)),
    .rdata_o (ord_rd)
  );

  obsl_ram #(.W($bits(level_t)), .D(LEVEL_SLOTS)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .re_i    (lvl_re),
    .raddr_i (lvl_raddr),
    .rdata_o (lvl_rd)
  );

  assign lvl_re    = cmd_i.lvl_read | cmd_i.scan_step;
  assign lvl_raddr = cmd_i.lvl_read ? ord_rd.lvl : scan_idx_q;

  // Status back to the sequencer.
  always_comb begin
    sts_o = '0;
    sts_o.clr_last  = (clr_idx_q == OAW'(ORDER_SLOTS - 1));
    sts_o.is_insert = (act_q == ACT_INSERT);
    sts_o.scan_last = (scan_idx_q == LAW'(LEVEL_SLOTS - 1));
    sts_o.late_err  = late_err_q;
    if (slot_bad_q) begin
      sts_o.early_err = 1'b1;
    end else if (act_q == ACT_INSERT) begin
      sts_o.early_err = ord_rd.resting || (price_q == '0) || (qty_q == '0) ||
                        (exe_q >= qty_q);
    end else begin
      sts_o.early_err = !ord_rd.resting;
    end
  end

  // Update of a resting order: remove, take or revise.
  logic        detach;
  logic [31:0] sub_r, x_sum;
  logic [10:0] dec_cnt, x_cnt;
  logic        x_freed;
  logic [32:0] exe_sum;
  order_t      x_ord;

  always_comb begin
    detach  = (act_q == ACT_REMOVE) || !lt_q;
    sub_r   = (lvl_rd.sum >= ord_rd.residual) ? lvl_rd.sum - ord_rd.residual : '0;
    dec_cnt = (lvl_rd.count != '0) ? lvl_rd.count - 11'd1 : '0;
    exe_sum = {1'b0, ord_rd.executed} + {1'b0, qty_q};
    x_ord   = ord_rd;
    if (detach) begin
      x_sum   = sub_r;
      x_cnt   = dec_cnt;
      x_freed = (dec_cnt == '0);
      x_ord.resting  = 1'b0;
      x_ord.residual = (act_q == ACT_REMOVE) ? ord_rd.residual : '0;
    end else begin
      x_sum   = lvl_rd.sum - delta_q;
      x_cnt   = lvl_rd.count;
      x_freed = 1'b0;
      x_ord.residual = ord_rd.residual - delta_q;
    end
    case (act_q)
      ACT_TAKE: begin
        x_ord.phase    = PH_TRADED;
        x_ord.executed = exe_sum[32] ? '1 : exe_sum[31:0];
        x_ord.mtime    = now_q;
      end
      ACT_REVISE: begin
        x_ord.phase = PH_REVISED;
        x_ord.total = qty_q;
        x_ord.mtime = now_q;
      end
      default: begin
        x_ord.phase = PH_OFF;
      end
    endcase
  end

  // Insert after the level scan.
  logic [32:0]    ins_sum;
  status_e        ins_st;
  logic [LAW-1:0] ins_li;
  level_t         ins_lvl;
  order_t         ins_ord;

  always_comb begin
    ins_sum = {1'b0, found_w_q.sum} + {1'b0, resd_q};
    ins_lvl = '{key: key_q, sum: resd_q, count: 11'd1};
    ins_li  = free_idx_q;
    if (found_v_q) begin
      ins_st  = ins_sum[32] ? ST_ILLEGAL : ST_OK;
      ins_li  = found_idx_q;
      ins_lvl = '{key: found_w_q.key, sum: ins_sum[31:0],
                  count: found_w_q.count + 11'd1};
    end else if (free_v_q) begin
      ins_st = ST_OK;
    end else begin
      ins_st = ST_FULL;
    end
    ins_ord = '{resting: 1'b1, lvl: ins_li, residual: resd_q, executed: exe_q,
                total: qty_q, minimum: min_q, price: price_q, phase: PH_NEW,
                mtime: ord_rd.mtime};
  end

  // Memory write ports.
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = slot_q;
    ord_wdata = x_ord;
    lvl_we    = 1'b0;
    lvl_waddr = ord_rd.lvl;
    lvl_wdata = '{key: lvl_rd.key, sum: x_sum, count: x_cnt};
    if (cmd_i.clr_step) begin
      ord_we    = 1'b1;
      ord_waddr = clr_idx_q;
      ord_wdata = '0;
    end else if (cmd_i.exec_upd) begin
      ord_we = 1'b1;
      lvl_we = 1'b1;
    end else if (cmd_i.ins_upd && ins_st == ST_OK) begin
      ord_we    = 1'b1;
      ord_wdata = ins_ord;
      lvl_we    = 1'b1;
      lvl_waddr = ins_li;
      lvl_wdata = ins_lvl;
    end
  end

  // Captured command and per-item working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q      <= action_e'(action_i);
      slot_q     <= OAW'(order_slot_i);
      slot_bad_q <= (32'(order_slot_i) >= 32'(ORDER_SLOTS));
      key_q      <= is_buy_i ? 33'd0 - {2'b00, price_ticks_i} : {2'b00, price_ticks_i};
      price_q    <= price_ticks_i;
      qty_q      <= lot_quantity_i;
      exe_q      <= executed_lots_i;
      min_q      <= minimum_lots_i;
      now_q      <= timestamp_i;
      resd_q     <= lot_quantity_i - executed_lots_i;
    end
    if (cmd_i.check) begin
      if (act_q == ACT_TAKE) begin
        delta_q    <= qty_q;
        lt_q       <= qty_q < ord_rd.residual;
        late_err_q <= qty_q > ord_rd.residual;
      end else if (act_q == ACT_REVISE) begin
        delta_q    <= ord_rd.total - qty_q;
        lt_q       <= (ord_rd.total - qty_q) < ord_rd.residual;
        late_err_q <= (qty_q == '0) || (qty_q < ord_rd.executed) ||
                      (qty_q < ord_rd.minimum) || (qty_q > ord_rd.total) ||
                      ((ord_rd.total - qty_q) > ord_rd.residual);
      end else begin
        delta_q    <= '0;
        lt_q       <= 1'b0;
        late_err_q <= 1'b0;
      end
    end
    if (cmd_i.scan_init) begin
      scan_idx_q <= '0;
      chk_v_q    <= 1'b0;
      found_v_q  <= 1'b0;
      free_v_q   <= 1'b0;
    end
    if (cmd_i.scan_step) begin
      scan_idx_q <= scan_idx_q + LAW'(1);
      chk_v_q    <= 1'b1;
      chk_idx_q  <= scan_idx_q;
    end
    if (cmd_i.scan_flush) begin
      chk_v_q <= 1'b0;
    end
    // The first matching key and the lowest free slot win.
    if ((cmd_i.scan_step || cmd_i.scan_flush) && chk_v_q) begin
      if (in_use_q[chk_idx_q]) begin
        if (!found_v_q && lvl_rd.key == key_q) begin
          found_v_q   <= 1'b1;
          found_idx_q <= chk_idx_q;
          found_w_q   <= lvl_rd;
        end
      end else if (!free_v_q) begin
        free_v_q   <= 1'b1;
        free_idx_q <= chk_idx_q;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fail || (cmd_i.ins_upd && ins_st != ST_OK)) begin
      status_q    <= cmd_i.fail ? ST_ILLEGAL : ins_st;
      res_price_q <= '0;
      res_total_q <= '0;
      res_count_q <= '0;
      res_resid_q <= '0;
      res_exec_q  <= '0;
      res_phase_q <= PH_NEW;
    end else if (cmd_i.exec_upd) begin
      status_q    <= ST_OK;
      res_price_q <= ord_rd.price;
      res_total_q <= x_freed ? '0 : x_sum;
      res_count_q <= x_freed ? '0 : x_cnt;
      res_resid_q <= x_ord.residual;
      res_exec_q  <= x_ord.executed;
      res_phase_q <= x_ord.phase;
    end else if (cmd_i.ins_upd) begin
      status_q    <= ST_OK;
      res_price_q <= price_q;
      res_total_q <= ins_lvl.sum;
      res_count_q <= ins_lvl.count;
      res_resid_q <= resd_q;
      res_exec_q  <= exe_q;
      res_phase_q <= PH_NEW;
    end
  end

  // Control state: strobe, level occupancy, clear pointer, last trade.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      in_use_q     <= '0;
      clr_idx_q    <= '0;
      last_price_q <= '0;
      last_lots_q  <= '0;
      last_time_q  <= '0;
    end else begin
      valid_q <= cmd_i.fail || cmd_i.exec_upd || cmd_i.ins_upd;
      if (cmd_i.clr_step) clr_idx_q <= clr_idx_q + OAW'(1);
      if (cmd_i.exec_upd) begin
        if (x_freed) in_use_q[ord_rd.lvl] <= 1'b0;
        if (act_q == ACT_TAKE) begin
          last_price_q <= ord_rd.price;
          last_lots_q  <= qty_q;
          last_time_q  <= now_q;
        end
      end
      if (cmd_i.ins_upd && ins_st == ST_OK) begin
        in_use_q[ins_li] <= 1'b1;
      end
    end
  end

  assign valid_o                = valid_q;
  assign status_o               = status_q;
  assign level_price_o          = res_price_q;
  assign level_total_lots_o     = res_total_q;
  assign level_order_count_o    = res_count_q;
  assign order_resting_lots_o   = res_resid_q;
  assign order_executed_total_o = res_exec_q;
  assign order_status_o         = res_phase_q;
  assign last_trade_price_o     = last_price_q;
  assign last_trade_lots_o      = last_lots_q;
  assign last_trade_time_o      = last_time_q;

endmodule

/* sv/order_book_side_levels.sv */
// One side of an order book, aggregated by price level.
// A command transfer happens at a rising clock edge where start_i is high
// and busy_o is low; the action, order slot and quantity fields are taken
// from their ports at that edge. Every command gives exactly one result,
// which sits on the result ports for one cycle marked by valid_o. The
// receiver cannot stall, so it must take each result in that cycle.
// Remove, take and revise go from transfer to result through these steps:
// a read of the order table, a read of the order's level, a check step
// and an update step that writes both tables. busy_o drops while the
// result is shown, so a new command is taken only once the last result is out.
// Insert looks up the level by its price key with a linear pass over the
// level table, one entry per cycle through its read port, so the pass
// covers all LEVEL_SLOTS entries.
// Errors found on the order read are reported without the later steps.
// The last trade ports always show the side's most recent trade.
// After reset the block sweeps the order table to clear its resting flags,
// one entry per cycle; busy_o stays high until all ORDER_SLOTS entries are swept.
`timescale 1ns / 1ps
`include "order_book_side_levels_defines.svh"
module order_book_side_levels (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [9:0]  order_slot_i,
  input  logic        is_buy_i,
  input  logic [30:0] price_ticks_i,
  input  logic [31:0] lot_quantity_i,
  input  logic [31:0] executed_lots_i,
  input  logic [31:0] minimum_lots_i,
  input  logic [47:0] timestamp_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [30:0] level_price_o,
  output logic [31:0] level_total_lots_o,
  output logic [10:0] level_order_count_o,
  output logic [31:0] order_resting_lots_o,
  output logic [31:0] order_executed_total_o,
  output logic [1:0]  order_status_o,
  output logic [30:0] last_trade_price_o,
  output logic [31:0] last_trade_lots_o,
  output logic [47:0] last_trade_time_o
);
  import obsl_pkg::*;

  // The sequencer and the datapath talk only through these two groups.
  cmd_t cmd;
  sts_t sts;

  obsl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  obsl_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .action_i               (action_i),
    .order_slot_i           (order_slot_i),
    .is_buy_i               (is_buy_i),
    .price_ticks_i          (price_ticks_i),
    .lot_quantity_i         (lot_quantity_i),
    .executed_lots_i        (executed_lots_i),
    .minimum_lots_i         (minimum_lots_i),
    .timestamp_i            (timestamp_i),
    .valid_o                (valid_o),
    .status_o               (status_o),
    .level_price_o          (level_price_o),
    .level_total_lots_o     (level_total_lots_o),
    .level_order_count_o    (level_order_count_o),
    .order_resting_lots_o   (order_resting_lots_o),
    .order_executed_total_o (order_executed_total_o),
    .order_status_o         (order_status_o),
    .last_trade_price_o     (last_trade_price_o),
    .last_trade_lots_o      (last_trade_lots_o),
    .last_trade_time_o      (last_trade_time_o)
  );

  // A result appears once the block is back in idle, never twice in a row.
  `OBSL_ASSERT_IMP(a_result_when_idle, valid_o, !busy_o, "result while busy")
  `OBSL_ASSERT_NXT(a_single_strobe, valid_o, !valid_o, "result strobe held")
  `OBSL_ASSERT_NXT(a_busy_after_start, start_i && !busy_o, busy_o, "not busy after start")
  // A failed command reports no level or order contents.
  `OBSL_ASSERT_IMP(a_error_zeroes, valid_o && (status_o != ST_OK),
    (level_total_lots_o == '0) && (level_order_count_o == '0) &&
    (order_resting_lots_o == '0), "error result carries data")

endmodule
